// File: src/fir32_pkg.sv
// Shared constants, types and coefficient table of the 32-tap FIR filter.
package fir32_pkg;

    localparam int TAP_COUNT    = 32;
    localparam int SAMPLE_BITS  = 12;
    localparam int COEF_BITS    = 16;
    localparam int FRAC_BITS    = COEF_BITS - 1;
    localparam int ACC_BITS     = 32;
    localparam int OFFSET_BITS  = 13;
    localparam int OUT_BITS     = 12;
    localparam int PROD_BITS    = SAMPLE_BITS + 1 + COEF_BITS;
    localparam int TAP_IDX_BITS = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int TABLE_LEN    = 32;

    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(4095);
    localparam logic [OUT_BITS-1:0]    OUT_MAX      = OUT_BITS'(4095);
    localparam logic [TAP_IDX_BITS-1:0] LAST_TAP    = TAP_IDX_BITS'(TAP_COUNT - 1);

    // Q1.15 coefficients, symmetric, tap 0 pairs with the newest sample
    localparam int COEF_ROM [TABLE_LEN] = '{
        47, -53, -204, -442, -767, -1135, -1460, -1634,
        -1557, -1165, -456, 505, 1589, 2625, 3439, 3887,
        3887, 3439, 2625, 1589, 505, -456, -1165, -1557,
        -1634, -1460, -1135, -767, -442, -204, -53, 47
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_LAST,
        S_SAT
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

    typedef struct packed {
        logic load;
        logic rotate;
    } t_line_ctl;

    // Coefficient for a tap; taps past the table weigh zero.
    function automatic logic signed [COEF_BITS-1:0] coef_at(
        input logic [TAP_IDX_BITS-1:0] idx
    );
        int unsigned ii;
        logic signed [COEF_BITS-1:0] c;
        ii = 32'(idx);
        c  = '0;
        if (ii < TABLE_LEN) begin
            c = COEF_BITS'(COEF_ROM[ii]);
        end
        return c;
    endfunction

endpackage

// File: src/fir32_if.sv
// Valid/ready channel interfaces for sample items and result items.
interface fir32_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [fir32_pkg::SAMPLE_BITS-1:0]    adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface fir32_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [fir32_pkg::OUT_BITS-1:0]       dac_code;
    logic                                 saturated;

    modport source (output valid, output dac_code, output saturated, input ready);
    modport sink   (input valid, input dac_code, input saturated, output ready);
endinterface

// File: src/fir32_tap_line.sv
// Delay line as a rotating shift register: one stored sample leaves per cycle while rotating.
module fir32_tap_line (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fir32_pkg::t_line_ctl               i_ctl,
    input  logic [fir32_pkg::SAMPLE_BITS-1:0]  i_sample,
    output logic [fir32_pkg::SAMPLE_BITS-1:0]  o_tap
);

    logic [fir32_pkg::SAMPLE_BITS-1:0] r_line [fir32_pkg::TAP_COUNT];

    // load: shift in newest at the front, drop oldest.
    // rotate: front goes to the back; a full turn restores the order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fir32_pkg::TAP_COUNT; i++) begin
                r_line[i] <= '0;
            end
        end else if (i_ctl.load) begin
            r_line[0] <= i_sample;
            for (int i = 1; i < fir32_pkg::TAP_COUNT; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end else if (i_ctl.rotate) begin
            r_line[fir32_pkg::TAP_COUNT-1] <= r_line[0];
            for (int i = 0; i < fir32_pkg::TAP_COUNT - 1; i++) begin
                r_line[i] <= r_line[i+1];
            end
        end
    end

    assign o_tap = r_line[0];

endmodule

// File: src/fir32_mac.sv
// Single multiply-accumulate unit: registered product, then 32-bit accumulate.
module fir32_mac (
    input  logic                                   i_clk,
    input  fir32_pkg::t_mac_ctl                    i_ctl,
    input  logic [fir32_pkg::SAMPLE_BITS-1:0]      i_tap,
    input  logic [fir32_pkg::TAP_IDX_BITS-1:0]     i_tap_idx,
    input  logic [fir32_pkg::OFFSET_BITS-1:0]      i_offset,
    output logic signed [fir32_pkg::ACC_BITS-1:0]  o_acc
);

    logic signed [fir32_pkg::COEF_BITS-1:0] w_coef;
    logic signed [fir32_pkg::PROD_BITS-1:0] w_prod;
    logic signed [fir32_pkg::PROD_BITS-1:0] r_prod;
    logic signed [fir32_pkg::ACC_BITS-1:0]  w_prod_ext;
    logic signed [fir32_pkg::ACC_BITS-1:0]  w_offset_ext;
    logic signed [fir32_pkg::ACC_BITS-1:0]  r_acc;

    assign w_coef = fir32_pkg::coef_at(i_tap_idx);
    assign w_prod = $signed({1'b0, i_tap}) * w_coef;

    assign w_prod_ext = {{(fir32_pkg::ACC_BITS - fir32_pkg::PROD_BITS){r_prod[fir32_pkg::PROD_BITS-1]}},
                         r_prod};
    // offset is in half codes: scale by 2^(FRAC_BITS-1)
    assign w_offset_ext = fir32_pkg::ACC_BITS'({i_offset, {(fir32_pkg::FRAC_BITS - 1){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.clear) begin
            r_acc <= w_offset_ext;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: src/fir32_out.sv
// Saturation to the output code range and the result output register.
module fir32_out (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic signed [fir32_pkg::ACC_BITS-1:0]  i_acc,
    output logic                                   o_free,
    fir32_out_if.source                            o_result
);

    localparam logic signed [fir32_pkg::ACC_BITS-1:0] LIMIT =
        fir32_pkg::ACC_BITS'({fir32_pkg::OUT_MAX, {fir32_pkg::FRAC_BITS{1'b0}}});

    logic                              r_valid;
    logic [fir32_pkg::OUT_BITS-1:0]    r_code;
    logic                              r_sat;
    logic [fir32_pkg::OUT_BITS-1:0]    w_code;
    logic                              w_sat;

    always_comb begin
        priority if (i_acc[fir32_pkg::ACC_BITS-1]) begin
            w_code = '0;
            w_sat  = 1'b1;
        end else if (i_acc > LIMIT) begin
            w_code = fir32_pkg::OUT_MAX;
            w_sat  = 1'b1;
        end else begin
            w_code = i_acc[fir32_pkg::FRAC_BITS +: fir32_pkg::OUT_BITS];
            w_sat  = 1'b0;
        end
    end

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= w_code;
            r_sat  <= w_sat;
        end
    end

    assign o_result.valid     = r_valid;
    assign o_result.dac_code  = r_code;
    assign o_result.saturated = r_sat;

    // a clamped result sits on one of the two rails
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sat) |-> (r_code == '0 || r_code == fir32_pkg::OUT_MAX))
        else $error("saturated result not on a rail");

endmodule

// File: src/fir32_adc_to_dac_filter_unit.sv
// Top level of the 32-tap FIR filter, converter sample in, converter code out.
// A new sample is taken only in idle, after the last one has passed every tap and gone to the
// output stage; the one shared multiplier takes one tap per cycle.
// The next sample is taken while an earlier result still waits at the output.
// Reset (sync, active low): delay line cleared to zero, offset register set to 4095.
module fir32_adc_to_dac_filter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fir32_pkg::OFFSET_BITS-1:0]   i_cfg_wr_data,
    fir32_in_if.sink                            i_sample,
    fir32_out_if.source                         o_result
);

    fir32_pkg::t_state                       r_state;
    fir32_pkg::t_state                       n_state;
    logic [fir32_pkg::TAP_IDX_BITS-1:0]      r_tap_cnt;
    logic [fir32_pkg::TAP_IDX_BITS-1:0]      n_tap_cnt;
    logic [fir32_pkg::OFFSET_BITS-1:0]       r_offset;

    fir32_pkg::t_mac_ctl                     w_mac;
    fir32_pkg::t_line_ctl                    w_line;
    logic                                    w_in_ready;
    logic                                    w_out_load;
    logic                                    w_out_free;
    logic [fir32_pkg::SAMPLE_BITS-1:0]       w_tap;
    logic signed [fir32_pkg::ACC_BITS-1:0]   w_acc;

    // offset register, half output codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= fir32_pkg::OFFSET_RESET;
        end else if (i_cfg_wr_en) begin
            r_offset <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fir32_pkg::S_IDLE;
            r_tap_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_tap_cnt <= n_tap_cnt;
        end
    end

    // Sequencer: load sample, multiply each tap in turn (each accumulate adds the product
    // registered for the tap before), a final accumulate, then hand the sum to the output stage.
    always_comb begin
        n_state    = r_state;
        n_tap_cnt  = r_tap_cnt;
        w_mac      = '0;
        w_line     = '0;
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            fir32_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_sample.valid) begin
                    w_mac.clear = 1'b1;
                    w_line.load = 1'b1;
                    n_tap_cnt   = '0;
                    n_state     = fir32_pkg::S_MAC;
                end
            end
            fir32_pkg::S_MAC: begin
                w_mac.mul_en  = 1'b1;
                w_mac.acc_en  = (r_tap_cnt != '0);
                w_line.rotate = 1'b1;
                if (r_tap_cnt == fir32_pkg::LAST_TAP) begin
                    n_state = fir32_pkg::S_LAST;
                end else begin
                    n_tap_cnt = r_tap_cnt + 1'b1;
                end
            end
            fir32_pkg::S_LAST: begin
                w_mac.acc_en = 1'b1;
                n_state      = fir32_pkg::S_SAT;
            end
            fir32_pkg::S_SAT: begin
                // waits here only while the previous result is still unclaimed
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = fir32_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fir32_pkg::S_IDLE;
            end
        endcase
    end

    assign i_sample.ready = w_in_ready;

    fir32_tap_line u_tap_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_line),
        .i_sample (i_sample.adc_sample),
        .o_tap    (w_tap)
    );

    fir32_mac u_mac (
        .i_clk     (i_clk),
        .i_ctl     (w_mac),
        .i_tap     (w_tap),
        .i_tap_idx (r_tap_cnt),
        .i_offset  (r_offset),
        .o_acc     (w_acc)
    );

    fir32_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_load),
        .i_acc    (w_acc),
        .o_free   (w_out_free),
        .o_result (o_result)
    );

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=>
            (r_state == fir32_pkg::S_MAC && r_tap_cnt == '0))
        else $error("accepted item did not start at tap 0");

    a_last_after_full_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir32_pkg::S_LAST) |->
            ($past(r_state) == fir32_pkg::S_MAC && $past(r_tap_cnt) == fir32_pkg::LAST_TAP))
        else $error("final accumulate without a full tap pass");

    a_load_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_result.valid && r_state == fir32_pkg::S_IDLE))
        else $error("result load did not present an item");

endmodule

// File: tb/sv/fir32_dac_checker.sv
`timescale 1ns / 100ps
// Output checker of the FIR filter: predicts each output code from the watched samples.
module fir32_dac_checker
    import fir32_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [OFFSET_BITS-1:0] i_cfg_wr_data,
    fir32_in_if                    smp,
    fir32_out_if                   res,
    output int                     o_mismatches,
    output int                     o_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [OUT_BITS-1:0] code;
        logic                sat;
    } dac_result_t;

    logic [SAMPLE_BITS-1:0] delay_line [TAP_COUNT];
    logic [OFFSET_BITS-1:0] offset_half;
    dac_result_t            dac_expected_q [$];
    dac_result_t            got;
    dac_result_t            want;
    int                     mismatch_count = 0;
    int                     tap;

    // Q.15 sum of products plus offset, clamped to the output code range
    function automatic dac_result_t filter_output(
        input logic [SAMPLE_BITS-1:0] line [TAP_COUNT],
        input logic [OFFSET_BITS-1:0] offs
    );
        longint      acc;
        longint      full_q15;
        dac_result_t r;
        int          i;
        acc = 0;
        for (i = 0; i < TAP_COUNT; i++) begin
            if (i < TABLE_LEN) begin
                acc += longint'(COEF_ROM[i]) * longint'(line[i]);
            end
        end
        // one offset LSB is half an output code
        acc += longint'(offs) << (FRAC_BITS - 1);
        full_q15 = longint'(OUT_MAX) << FRAC_BITS;
        if (acc < 0) begin
            r.code = '0;
            r.sat  = 1'b1;
        end else if (acc > full_q15) begin
            r.code = OUT_MAX;
            r.sat  = 1'b1;
        end else begin
            r.code = OUT_BITS'(acc >>> FRAC_BITS);
            r.sat  = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (delay_line[n]) delay_line[n] = '0;
            offset_half = OFFSET_RESET;
            dac_expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                offset_half = i_cfg_wr_data;
            end
            if (res.valid && res.ready) begin
                got.code = res.dac_code;
                got.sat  = res.saturated;
                if (dac_expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("%0t: result item with none expected: code %0d sat %0b",
                                 $realtime, got.code, got.sat);
                    end
                end else begin
                    want = dac_expected_q.pop_front();
                    if (got.code !== want.code || got.sat !== want.sat) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("%0t: dac_code exp %0d got %0d, saturated exp %0b got %0b",
                                     $realtime, want.code, got.code, want.sat, got.sat);
                        end
                    end
                end
            end
            if (smp.valid && smp.ready) begin
                for (tap = TAP_COUNT - 1; tap > 0; tap--) begin
                    delay_line[tap] = delay_line[tap - 1];
                end
                delay_line[0] = smp.adc_sample;
                dac_expected_q.push_back(filter_output(delay_line, offset_half));
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= dac_expected_q.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top of the FIR filter: sample items, offset writes, output stalls, verdict.
module testbench;
    import fir32_pkg::*;

    localparam int IDLE_MAX       = 19;    // longest per-item wait on either side
    localparam int RANDOM_ITEMS   = 1250;
    localparam int PHASES         = 8;
    localparam int HOLD_AT        = 300;   // result count at which the long stall starts
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;    // settle time before the verdict
    localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles allowed before a hang is called

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [OFFSET_BITS-1:0] cfg_wr_data;
    logic                   no_idle;
    logic [SAMPLE_BITS-1:0] last_sample;
    int                     mismatches;
    int                     pending;
    int                     quiet_cycles = 0;
    int                     results_taken;

    fir32_in_if  sample_ch ();
    fir32_out_if result_ch ();

    fir32_adc_to_dac_filter_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_sample      (sample_ch),
        .o_result      (result_ch)
    );

    // Watches both channels and the offset writes, keeps its own filter state.
    fir32_dac_checker dac_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .smp           (sample_ch),
        .res           (result_ch),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 20 ns clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Offer one sample item after a random wait, hold it until the edge that takes it.
    // valid stays high between back-to-back items, so it is never dropped and raised
    // in the same step.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= value;
        do @(posedge clk); while (!sample_ch.ready);
        last_sample = value;
    endtask

    // Stop offering and wait until every predicted output item has come back.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Offset register is only written with the filter idle.
    task automatic write_offset(input logic [OFFSET_BITS-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Mix of uniform codes, rail values, near-rail codes and runs of one code;
    // the runs drive the step response far enough to hit both clamps.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] prev);
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = SAMPLE_BITS'($urandom);
            4:          v = '0;
            5:          v = '1;
            6, 7, 8:    v = prev;
            default: begin
                v = SAMPLE_BITS'($urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v;
                end
            end
        endcase
        return v;
    endfunction

    // Result side: random back-pressure per item, plus one long stall while the
    // sender keeps offering, so the filter fills up and stops taking samples.
    initial begin
        int gap;
        result_ch.ready <= 1'b0;
        results_taken = 0;
        @(posedge clk);
        forever begin
            if (results_taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            results_taken++;
        end
    end

    // Watchdog: a long run of cycles with no item moving on either side is a hang.
    always @(posedge clk) begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        int per_phase;
        int n;
        logic [OFFSET_BITS-1:0] offs;

        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.adc_sample <= '0;
        no_idle              <= 1'b0;
        last_sample          = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The delay line is still all zero from reset here.
        // Offset left at its reset value: zero input gives mid-scale.
        send_sample('0);
        send_sample('0);
        // Full-range offset with empty history: exactly 4095.0, no clamp.
        write_offset(OFFSET_BITS'(8190));
        send_sample('0);
        send_sample('0);
        // One above the stated range: 4095.5 counts as over and clamps.
        write_offset(OFFSET_BITS'(8191));
        send_sample('0);
        // Zero offset with an impulse: negative taps pull the sum below zero.
        write_offset('0);
        send_sample('1);
        send_sample('0);
        send_sample('0);
        send_sample('0);
        // Back to mid-scale: full-scale run, alternating bit patterns, a small code, a mid-scale code.
        write_offset(OFFSET_RESET);
        repeat (6) send_sample('1);
        send_sample(SAMPLE_BITS'('hAAA));
        send_sample(SAMPLE_BITS'('h555));
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'('h800));
        // High offset on a full-scale history: clamps at the top.
        write_offset(OFFSET_BITS'(8190));
        repeat (4) send_sample('1);

        // Random part: one offset setting per phase, extremes first.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       offs = OFFSET_BITS'(8190);
                1:       offs = '0;
                2:       offs = OFFSET_BITS'(1);
                3:       offs = OFFSET_BITS'(8191);
                7:       offs = OFFSET_RESET;
                default: offs = OFFSET_BITS'($urandom_range(0, 8191));
            endcase
            write_offset(offs);
            for (n = 0; n < per_phase; n++) begin
                // every 40 items, sometimes switch to a stretch with no waits
                if (n % 40 == 0) begin
                    no_idle <= ($urandom_range(0, 3) == 0);
                end
                send_sample(pick_sample(last_sample));
            end
        end

        // All items offered: wait for the last results, then let the pipe settle.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
